@@ design/frat_pkg.sv @@
// shared types and constants for the fragment reassembly ack tracker
package frat_pkg;

  // fixed field widths
  localparam int MSG_W   = 32;
  localparam int IDX_W   = 32;
  localparam int TOTAL_W = 11;
  localparam int LIMIT_W = 16;
  localparam int FAIL_W  = 17;
  localparam int ACK_W   = 32;
  localparam int NEXT_W  = 11;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 2;

  // fail count saturates at all ones
  localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

  // input op codes
  localparam logic OP_FRAGMENT = 1'b0;
  localparam logic OP_TIMEOUT  = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_EXPECTED_MESSAGE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAGMENT_TOTAL   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FAIL_LIMIT       = 2'd2;

  // configuration reset values
  localparam logic [MSG_W-1:0]   RST_EXPECTED_MESSAGE = '0;
  localparam logic [TOTAL_W-1:0] RST_FRAGMENT_TOTAL   = 11'd1;
  localparam logic [LIMIT_W-1:0] RST_FAIL_LIMIT       = 16'd50;

  // transfer status codes
  localparam logic [1:0] STAT_RUN    = 2'd0;
  localparam logic [1:0] STAT_DONE   = 2'd1;
  localparam logic [1:0] STAT_FAILED = 2'd2;

  // sequencer states
  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_LOOKUP   = 7'b0000100,
    ST_UPDATE   = 7'b0001000,
    ST_WALK_RD  = 7'b0010000,
    ST_WALK_CHK = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  // one result word as held in the output register
  typedef struct packed {
    logic              store_payload;
    logic              ack_valid;
    logic [ACK_W-1:0]  ack_sequence;
    logic [NEXT_W-1:0] next_missing;
    logic              transfer_done;
    logic              transfer_failed;
  } result_t;

endpackage

@@ design/frat_ram.sv @@
// generic single-write, single-read ram with registered read data
module frat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/fragment_reassembly_ack_tracker_top.sv @@
// top level of the fragment reassembly ack tracker
//
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  op, packet_message, packet_index
// result    out        out_valid / out_stall store_payload, ack_valid, ack_sequence,
//                                           next_missing, transfer_done, transfer_failed
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// a word passes through accept, map read, map update and result load when no batch ends;
// a batch end adds a map read and check per received fragment skipped plus a final read,
// or read and check, all set by the single map ram read port and its registered read data.
// after reset a clearing pass writes every map entry with in_stall high; config writes
// are taken at all times (cfg_ready is always high).
// a finished result waits in the output register while the next word is accepted;
// a further result waits in the emit state until out_stall drops.
module fragment_reassembly_ack_tracker_top
  import frat_pkg::*;
#(
  parameter int MAX_FRAGMENTS = 1024,
  parameter int BATCH_SIZE    = 10
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [MSG_W-1:0]   packet_message,
  input  logic [IDX_W-1:0]   packet_index,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               store_payload,
  output logic               ack_valid,
  output logic [ACK_W-1:0]   ack_sequence,
  output logic [NEXT_W-1:0]  next_missing,
  output logic               transfer_done,
  output logic               transfer_failed,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_FRAGMENTS);
  localparam int PW = $clog2(MAX_FRAGMENTS + 1);
  localparam int SW = $clog2(BATCH_SIZE + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAGMENTS - 1);

  state_t              state;
  logic [MSG_W-1:0]    expected_message;
  logic [TOTAL_W-1:0]  fragment_total;
  logic [LIMIT_W-1:0]  fail_limit;
  logic [PW-1:0]       ptr;
  logic [SW-1:0]       slot;
  logic [FAIL_W-1:0]   fail_count;
  logic [ACK_W-1:0]    ack_counter;
  logic [1:0]          status;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       idx;
  logic                hit;
  logic                store_r;
  logic                ack_r;
  result_t             res;

  logic [PW-1:0]       total_eff;
  logic                hit_in;
  logic [PW-1:0]       remain;
  logic [SW-1:0]       len;
  logic [SW-1:0]       slot_inc;
  logic                batch_end;
  logic [FAIL_W-1:0]   fail_next;
  logic [1:0]          fin_status;
  logic                out_free;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [0:0]          ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [0:0]          ram_rdata;

  // received map
  frat_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FRAGMENTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective fragment total, clamped to 1..MAX_FRAGMENTS
  always_comb begin
    if (fragment_total == '0) begin
      total_eff = PW'(1);
    end else if (32'(fragment_total) > 32'(MAX_FRAGMENTS)) begin
      total_eff = PW'(MAX_FRAGMENTS);
    end else begin
      total_eff = PW'(fragment_total);
    end
  end

  // fragment match on the incoming word
  assign hit_in = (op == OP_FRAGMENT) && (packet_message == expected_message) &&
                  (packet_index < 32'(total_eff));

  // batch length and end of batch
  always_comb begin
    remain    = (ptr < total_eff) ? total_eff - ptr : '0;
    len       = (32'(remain) < 32'(BATCH_SIZE)) ? SW'(remain) : SW'(BATCH_SIZE);
    slot_inc  = slot + SW'(1);
    batch_end = (32'(slot_inc) >= 32'(len));
  end

  // fail count step
  always_comb begin
    if (hit) begin
      fail_next = (fail_count != '0) ? fail_count - FAIL_W'(1) : fail_count;
    end else begin
      fail_next = (fail_count != FAIL_MAX) ? fail_count + FAIL_W'(1) : fail_count;
    end
  end

  // status at a batch end, failure first
  always_comb begin
    if (fail_count >= FAIL_W'(fail_limit)) begin
      fin_status = STAT_FAILED;
    end else if (ptr >= total_eff) begin
      fin_status = STAT_DONE;
    end else begin
      fin_status = STAT_RUN;
    end
  end

  // map port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = 1'b1;
    ram_raddr = idx;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 1'b0;
      end
      ST_UPDATE: begin
        ram_we = hit;
      end
      ST_WALK_RD: begin
        ram_raddr = ptr[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_message <= RST_EXPECTED_MESSAGE;
      fragment_total   <= RST_FRAGMENT_TOTAL;
      fail_limit       <= RST_FAIL_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPECTED_MESSAGE: expected_message <= cfg_data;
        CFG_FRAGMENT_TOTAL:   fragment_total   <= cfg_data[TOTAL_W-1:0];
        CFG_FAIL_LIMIT:       fail_limit       <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      ptr         <= '0;
      slot        <= '0;
      fail_count  <= '0;
      ack_counter <= '0;
      status      <= STAT_RUN;
      store_r     <= 1'b0;
      ack_r       <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            store_r <= 1'b0;
            ack_r   <= 1'b0;
            if (status == STAT_RUN) begin
              state <= ST_LOOKUP;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_LOOKUP: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          store_r    <= hit && !ram_rdata[0];
          fail_count <= fail_next;
          if (batch_end) begin
            state <= ST_WALK_RD;
          end else begin
            slot  <= slot_inc;
            state <= ST_EMIT;
          end
        end
        ST_WALK_RD: begin
          if (ptr < total_eff) begin
            state <= ST_WALK_CHK;
          end else begin
            ack_counter <= ack_counter + ACK_W'(1);
            slot        <= '0;
            ack_r       <= 1'b1;
            status      <= fin_status;
            state       <= ST_EMIT;
          end
        end
        ST_WALK_CHK: begin
          if (ram_rdata[0]) begin
            ptr   <= ptr + PW'(1);
            state <= ST_WALK_RD;
          end else begin
            ack_counter <= ack_counter + ACK_W'(1);
            slot        <= '0;
            ack_r       <= 1'b1;
            status      <= fin_status;
            state       <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // captured input word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      idx <= packet_index[AW-1:0];
      hit <= hit_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      res.store_payload   <= store_r;
      res.ack_valid       <= ack_r;
      res.ack_sequence    <= ack_counter;
      res.next_missing    <= NEXT_W'(ptr);
      res.transfer_done   <= (status == STAT_DONE);
      res.transfer_failed <= (status == STAT_FAILED);
    end
  end

  assign store_payload   = res.store_payload;
  assign ack_valid       = res.ack_valid;
  assign ack_sequence    = res.ack_sequence;
  assign next_missing    = res.next_missing;
  assign transfer_done   = res.transfer_done;
  assign transfer_failed = res.transfer_failed;

`ifndef SYNTHESIS
  // a finished transfer keeps its status until reset
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    (status != STAT_RUN) |=> (status == $past(status)))
    else $error("finish status changed after the transfer ended");

  // done and failed are never reported together
  a_done_failed_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(transfer_done && transfer_failed))
    else $error("result reports both done and failed");

  // the walk never moves the pointer past the map
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PW'(MAX_FRAGMENTS))
    else $error("next-missing pointer beyond the map");

  // an ack entering the emit state always follows an ack counter step
  a_ack_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && $past(state) != ST_EMIT && ack_r) |->
      (ack_counter != $past(ack_counter)))
    else $error("acknowledgement without a counter step");
`endif

endmodule

@@ verif/tb_fragment_reassembly_ack_tracker_top.sv @@
// testbench for the fragment reassembly ack tracker: report scoreboard, word drivers, checks
module tb_fragment_reassembly_ack_tracker_top;
  import frat_pkg::*;

  localparam int MAX_FRAGS   = 1024;
  localparam int BATCH_LEN   = 10;
  localparam int QUIET_LIMIT = 20000;

  typedef enum {GEN_CLEAN, GEN_MIXED, GEN_BROKEN} word_mix_t;
  typedef enum {END_FILL, END_SHRINK, END_LIMIT_ONE, END_LIMIT_ZERO} finish_path_t;

  // tracks the receiver state and holds the reports still owed by the dut
  class reassembly_scoreboard;
    logic [MSG_W-1:0]   exp_msg;
    logic [TOTAL_W-1:0] frag_total;
    logic [LIMIT_W-1:0] fail_limit;
    bit                 rx_map [MAX_FRAGS];
    int unsigned        ptr;
    int unsigned        slot;
    logic [FAIL_W-1:0]  fails;
    logic [ACK_W-1:0]   acks;
    logic [1:0]         status;
    result_t            reports_due [$];
    int                 mismatches;

    function new();
      exp_msg    = RST_EXPECTED_MESSAGE;
      frag_total = RST_FRAGMENT_TOTAL;
      fail_limit = RST_FAIL_LIMIT;
      foreach (rx_map[i]) rx_map[i] = 1'b0;
      ptr        = 0;
      slot       = 0;
      fails      = '0;
      acks       = '0;
      status     = STAT_RUN;
      mismatches = 0;
    endfunction

    // fragment count as the block sees it
    function int unsigned live_total();
      if (frag_total == 0) return 1;
      if (frag_total > MAX_FRAGS) return MAX_FRAGS;
      return frag_total;
    endfunction

    // highest index not yet received, -1 when the map is full
    function int top_gap();
      for (int i = int'(live_total()) - 1; i >= 0; i--) begin
        if (!rx_map[i]) return i;
      end
      return -1;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_EXPECTED_MESSAGE: exp_msg = data;
        CFG_FRAGMENT_TOTAL:   frag_total = data[TOTAL_W-1:0];
        CFG_FAIL_LIMIT:       fail_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // one read attempt: update the map and counters, queue the report it causes
    function void take_word(logic word_op, logic [MSG_W-1:0] msg, logic [IDX_W-1:0] idx);
      int unsigned total;
      int unsigned remain;
      int unsigned len;
      result_t     rep;
      total = live_total();
      rep   = '0;
      if (status == STAT_RUN) begin
        if (word_op == OP_FRAGMENT && msg == exp_msg && idx < total) begin
          if (!rx_map[idx]) rep.store_payload = 1'b1;
          rx_map[idx] = 1'b1;
          if (fails != 0) fails--;
        end else if (fails != FAIL_MAX) begin
          fails++;
        end
        slot++;
        remain = (ptr < total) ? total - ptr : 0;
        len    = (remain < BATCH_LEN) ? remain : BATCH_LEN;
        // batch end: skip received fragments, send the ack, settle the outcome
        if (slot >= len) begin
          while (ptr < total && rx_map[ptr]) ptr++;
          acks++;
          slot          = 0;
          rep.ack_valid = 1'b1;
          if (fails >= fail_limit) status = STAT_FAILED;
          else if (ptr >= total) status = STAT_DONE;
        end
      end
      rep.ack_sequence    = acks;
      rep.next_missing    = NEXT_W'(ptr);
      rep.transfer_done   = (status == STAT_DONE);
      rep.transfer_failed = (status == STAT_FAILED);
      reports_due = {reports_due, rep};
    endfunction

    function void field_check(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_report(result_t got);
      result_t want;
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      field_check("store_payload", want.store_payload, got.store_payload);
      field_check("ack_valid", want.ack_valid, got.ack_valid);
      field_check("ack_sequence", want.ack_sequence, got.ack_sequence);
      field_check("next_missing", want.next_missing, got.next_missing);
      field_check("transfer_done", want.transfer_done, got.transfer_done);
      field_check("transfer_failed", want.transfer_failed, got.transfer_failed);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               op;
  logic [MSG_W-1:0]   packet_message;
  logic [IDX_W-1:0]   packet_index;
  logic               out_valid;
  logic               out_stall;
  logic               store_payload;
  logic               ack_valid;
  logic [ACK_W-1:0]   ack_sequence;
  logic [NEXT_W-1:0]  next_missing;
  logic               transfer_done;
  logic               transfer_failed;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  reassembly_scoreboard sb = new();

  fragment_reassembly_ack_tracker_top #(
    .MAX_FRAGMENTS(MAX_FRAGS),
    .BATCH_SIZE   (BATCH_LEN)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .packet_message (packet_message),
    .packet_index   (packet_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .store_payload  (store_payload),
    .ack_valid      (ack_valid),
    .ack_sequence   (ack_sequence),
    .next_missing   (next_missing),
    .transfer_done  (transfer_done),
    .transfer_failed(transfer_failed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall, redrawn every falling edge
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // report checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.match_report(result_t'{store_payload, ack_valid, ack_sequence, next_missing,
                                transfer_done, transfer_failed});
    end
  end

  // watchdog: too long without any word moving on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_fragment_reassembly_ack_tracker_top: FAIL");
    $finish;
  end

  // present one word, hold it until taken
  task automatic send_word(logic word_op, logic [MSG_W-1:0] msg, logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    op             <= word_op;
    packet_message <= msg;
    packet_index   <= idx;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.take_word(word_op, msg, idx);
    @(negedge clk);
  endtask

  // stop sending and wait for every owed report
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.reports_due.size() != 0);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // registers change only with the block idle
  task automatic program_regs(logic [MSG_W-1:0] msg, logic [TOTAL_W-1:0] total,
                              logic [LIMIT_W-1:0] limit);
    settle();
    write_reg(CFG_EXPECTED_MESSAGE, msg);
    write_reg(CFG_FRAGMENT_TOTAL, CFG_W'(total));
    write_reg(CFG_FAIL_LIMIT, CFG_W'(limit));
    cfg_valid <= 1'b0;
  endtask

  // mostly good fragments near the pointer; the top gap stays open so the transfer keeps running,
  // and failures are held back while they could end it (the broken mix sends only bad words)
  task automatic random_words(int count, word_mix_t mix);
    int unsigned      total;
    int unsigned      hi;
    int               hole;
    int               roll;
    logic             word_op;
    logic [MSG_W-1:0] msg;
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      total = sb.live_total();
      hole  = sb.top_gap();
      roll  = $urandom_range(0, 99);
      if (mix == GEN_CLEAN ||
          (mix == GEN_MIXED && (roll < 70 || int'(sb.fails) + 1 >= int'(sb.fail_limit)))) begin
        word_op = OP_FRAGMENT;
        msg     = sb.exp_msg;
        hi      = (sb.ptr + 24 < total) ? sb.ptr + 24 : total - 1;
        if ($urandom_range(0, 3) != 0) idx = $urandom_range(sb.ptr, hi);
        else idx = $urandom_range(0, total - 1);
        while (int'(idx) == hole && total > 1) idx = $urandom_range(0, total - 1);
      end else begin
        word_op = OP_FRAGMENT;
        msg     = sb.exp_msg;
        idx     = $urandom_range(0, total - 1);
        case ($urandom_range(0, 3))
          0: begin
            word_op = OP_TIMEOUT;
            msg     = $urandom;
            idx     = $urandom;
          end
          1: do msg = $urandom; while (msg == sb.exp_msg);
          2: idx = ($urandom_range(0, 1) != 0) ? $urandom_range(total, total + 8)
                                                : ($urandom | 32'h8000_0000);
          default: word_op = OP_TIMEOUT;
        endcase
      end
      send_word(word_op, msg, idx);
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, logic [MSG_W-1:0] msg,
                           logic [TOTAL_W-1:0] total, logic [LIMIT_W-1:0] limit, int count);
    // bring the fail count under the coming limit so the transfer keeps running
    while (sb.status == STAT_RUN && sb.fails >= limit) random_words(1, GEN_CLEAN);
    program_regs(msg, total, limit);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    random_words(count, GEN_MIXED);
  endtask

  // corner words: single-fragment totals, bad ids, out-of-range and duplicate indexes
  task automatic directed_words();
    program_regs('0, 11'd0, 16'hFFFF);
    send_word(OP_TIMEOUT, '1, '1);
    send_word(OP_FRAGMENT, '1, '0);
    send_word(OP_FRAGMENT, '0, 32'd1);
    send_word(OP_FRAGMENT, '0, '1);
    send_word(OP_TIMEOUT, '0, '0);
    program_regs('1, 11'd2047, 16'hFFFF);
    send_word(OP_FRAGMENT, '1, 32'd1023);
    send_word(OP_FRAGMENT, '1, 32'd1023);
    send_word(OP_FRAGMENT, '1, 32'd1024);
    send_word(OP_FRAGMENT, '1, 32'd2);
    send_word(OP_FRAGMENT, '1, 32'd1);
    send_word(OP_FRAGMENT, '0, 32'd0);
    send_word(OP_FRAGMENT, '1, 32'd0);
    send_word(OP_FRAGMENT, '1, 32'd3);
    send_word(OP_FRAGMENT, '1, 32'd4);
    send_word(OP_FRAGMENT, '1, 32'd4);
    send_word(OP_FRAGMENT, '1, 32'd5);
    send_word(OP_FRAGMENT, '1, 32'h8000_0000);
    send_word(OP_TIMEOUT, '1, 32'd6);
  endtask

  // main sequence
  initial begin
    finish_path_t path;
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_FRAGMENT;
    packet_message = '0;
    packet_index   = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_EXPECTED_MESSAGE;
    cfg_data       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_words();
    run_phase(29, 64, $urandom, 11'($urandom_range(200, 500)), 16'($urandom_range(3, 40)), 650);
    run_phase(64, 29, $urandom, 11'($urandom_range(600, 900)), 16'hFFFF, 650);
    run_phase(0, 0, $urandom, 11'd1024, 16'($urandom_range(3, 200)), 650);

    // limit of one: bring the fail count to zero, then good fragments only
    while (sb.status == STAT_RUN && sb.fails != 0) random_words(1, GEN_CLEAN);
    program_regs(sb.exp_msg, sb.frag_total, 16'd1);
    random_words(15, GEN_CLEAN);

    // close the transfer one of four ways
    path = finish_path_t'($urandom_range(0, 3));
    if (path == END_SHRINK && sb.ptr == 0) path = END_FILL;
    case (path)
      END_FILL: begin
        program_regs(sb.exp_msg, 11'd1024, 16'hFFFF);
        for (int i = 0; i < MAX_FRAGS; i++) begin
          if (!sb.rx_map[i]) send_word(OP_FRAGMENT, sb.exp_msg, i);
        end
      end
      END_SHRINK:    program_regs(sb.exp_msg, 11'd1, sb.fail_limit);
      END_LIMIT_ONE: program_regs(sb.exp_msg, sb.frag_total, 16'd1);
      default:       program_regs(sb.exp_msg, sb.frag_total, 16'd0);
    endcase
    while (sb.status == STAT_RUN) begin
      random_words(1, (path == END_LIMIT_ONE) ? GEN_BROKEN : GEN_MIXED);
    end

    // words after the finish are ignored
    random_words(12, GEN_MIXED);
    random_words(8, GEN_BROKEN);
    settle();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.reports_due.size() == 0)
      $display("tb_fragment_reassembly_ack_tracker_top: PASS");
    else
      $display("tb_fragment_reassembly_ack_tracker_top: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/frat_pkg.sv
design/frat_ram.sv
design/fragment_reassembly_ack_tracker_top.sv
verif/tb_fragment_reassembly_ack_tracker_top.sv
